// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define GMN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gmn assertion failed");

// next-cycle implication, checked out of reset
`define GMN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gmn assertion failed");

`endif

// ----- sv/gmn_pkg.sv -----
`default_nettype none
package gmn_pkg;
    localparam int GROUP_DEF = 32;
    localparam int GROUP_MAX = 64;
    localparam int CNT_W     = 7;
    localparam int SAMPLE_W  = 13;
    localparam int RES_W     = 14;
    localparam int SLOT_W    = 5;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [RES_W-1:0]    t_res;

    typedef struct packed {
        t_sample          median;
        logic [CNT_W-1:0] count;
    } t_job;

    typedef struct packed {
        logic busy;
        logic done;
    } t_back_stat;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SHIFT,
        S_WAIT
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_LOAD,
        B_OUT
    } t_back_state;
endpackage
`default_nettype wire

// ----- sv/gmn_if.sv -----
`default_nettype none
interface gmn_in_if;
    logic             valid;
    logic             ready;
    gmn_pkg::t_sample sample;
    logic             last_channel;

    modport source (output valid, sample, last_channel, input ready);
    modport sink   (input valid, sample, last_channel, output ready);
endinterface

interface gmn_out_if;
    logic                           valid;
    logic                           ready;
    gmn_pkg::t_sample               median_value;
    gmn_pkg::t_res                  residual;
    logic [gmn_pkg::SLOT_W-1:0]     channel_slot;
    logic                           last_result;

    modport source (output valid, median_value, residual, channel_slot, last_result,
                    input ready);
    modport sink   (input valid, median_value, residual, channel_slot, last_result,
                    output ready);
endinterface
`default_nettype wire

// ----- sv/gmn_ram.sv -----
`default_nettype none
module gmn_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 32
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- sv/gmn_queue.sv -----
`default_nettype none
module gmn_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire gmn_pkg::t_job i_data,
    output logic               o_ready,
    output logic               o_valid,
    output gmn_pkg::t_job      o_data,
    input  wire logic          i_pop,
    output logic [1:0]         o_level
);
    gmn_pkg::t_job r_mem [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_level;
    logic          push_ok;
    logic          pop_ok;

    assign o_ready = (r_level != 2'd2);
    assign o_valid = (r_level != 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign o_level = r_level;
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_level <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wptr <= ~r_wptr;
            end
            if (pop_ok) begin
                r_rptr <= ~r_rptr;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_level <= r_level + 2'd1;
                2'b01:   r_level <= r_level - 2'd1;
                default: r_level <= r_level;
            endcase
        end
        if (push_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule
`default_nettype wire

// ----- sv/gmn_front.sv -----
`default_nettype none
module gmn_front #(
    parameter int GROUP = gmn_pkg::GROUP_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    gmn_in_if.sink                                         i_in,
    output logic                                           o_we,
    output logic [(GROUP > 1 ? $clog2(GROUP) : 1)-1:0]     o_waddr,
    output gmn_pkg::t_sample                               o_wdata,
    output logic                                           o_push,
    output gmn_pkg::t_job                                  o_job,
    input  wire logic                                      i_push_ready,
    input  wire logic                                      i_done
);
    localparam int AW    = (GROUP > 1) ? $clog2(GROUP) : 1;
    localparam int CELLS = GROUP + 1;
    localparam int CW    = gmn_pkg::CNT_W;

    gmn_pkg::t_front_state r_state, n_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_shift;
    logic [CW-1:0]         r_jobcnt;
    gmn_pkg::t_sample      r_cell [CELLS];
    gmn_pkg::t_sample      ins [CELLS];
    logic [CELLS-1:0]      le;
    logic                  accept;
    logic                  room;
    logic [CW-1:0]         n_cnt;
    logic signed [13:0]    sum;
    logic signed [13:0]    sum_adj;
    gmn_pkg::t_sample      med;

    assign room    = (r_count < CW'(GROUP));
    assign accept  = i_in.valid && i_in.ready;
    assign n_cnt   = room ? r_count + CW'(1) : r_count;
    assign o_waddr = r_count[AW-1:0];
    assign o_wdata = i_in.sample;

    // ordered insertion of the new sample into the sorted cells
    always_comb begin
        for (int i = 0; i < CELLS; i++) begin
            le[i] = (CW'(i) < r_count) && (r_cell[i] <= i_in.sample);
        end
        ins[0] = le[0] ? r_cell[0] : i_in.sample;
        for (int i = 1; i < CELLS; i++) begin
            ins[i] = le[i] ? r_cell[i] : (le[i-1] ? i_in.sample : r_cell[i-1]);
        end
    end

    // after the shift, cell 0 and cell 1 hold the middle values
    always_comb begin
        sum     = {r_cell[0][12], r_cell[0]} + {r_cell[1][12], r_cell[1]};
        sum_adj = sum + 14'(sum[13]);
        med     = r_jobcnt[0] ? r_cell[0] : 13'(sum_adj >>> 1);
    end

    assign o_job.median = med;
    assign o_job.count  = r_jobcnt;

    always_comb begin
        n_state = r_state;
        case (r_state)
            gmn_pkg::S_LOAD: begin
                if (accept && i_in.last_channel) begin
                    n_state = gmn_pkg::S_SHIFT;
                end
            end
            gmn_pkg::S_SHIFT: begin
                if (r_shift == '0 && i_push_ready) begin
                    n_state = gmn_pkg::S_WAIT;
                end
            end
            gmn_pkg::S_WAIT: begin
                if (i_done) begin
                    n_state = gmn_pkg::S_LOAD;
                end
            end
            default: n_state = gmn_pkg::S_LOAD;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        o_push     = 1'b0;
        o_we       = 1'b0;
        case (r_state)
            gmn_pkg::S_LOAD: begin
                i_in.ready = 1'b1;
                o_we       = i_in.valid && room;
            end
            gmn_pkg::S_SHIFT: o_push = (r_shift == '0);
            gmn_pkg::S_WAIT:  o_push = 1'b0;
            default:          o_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gmn_pkg::S_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_count <= i_in.last_channel ? '0 : n_cnt;
            end
        end
        if (accept && room) begin
            for (int i = 0; i < CELLS; i++) begin
                r_cell[i] <= ins[i];
            end
        end else if (r_state == gmn_pkg::S_SHIFT && r_shift != '0) begin
            for (int i = 0; i < CELLS - 1; i++) begin
                r_cell[i] <= r_cell[i+1];
            end
            r_shift <= r_shift - CW'(1);
        end
        if (accept && i_in.last_channel) begin
            r_jobcnt <= n_cnt;
            r_shift  <= CW'((n_cnt - CW'(1)) >> 1);
        end
    end
endmodule
`default_nettype wire

// ----- sv/gmn_back.sv -----
`default_nettype none
module gmn_back #(
    parameter int GROUP = gmn_pkg::GROUP_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_job_valid,
    input  wire gmn_pkg::t_job                         i_job,
    output logic                                       o_pop,
    output logic [(GROUP > 1 ? $clog2(GROUP) : 1)-1:0] o_raddr,
    input  wire gmn_pkg::t_sample                      i_rdata,
    gmn_out_if.source                                  o_out,
    output gmn_pkg::t_back_stat                        o_stat
);
    localparam int AW = (GROUP > 1) ? $clog2(GROUP) : 1;
    localparam int CW = gmn_pkg::CNT_W;

    gmn_pkg::t_back_state r_state, n_state;
    logic [CW-1:0]        r_k;
    logic [CW-1:0]        r_n;
    gmn_pkg::t_sample     r_med;
    gmn_pkg::t_res        r_res;
    logic [gmn_pkg::SLOT_W-1:0] r_slot;
    logic                 r_last;
    logic                 capture;
    logic                 fire;
    logic [CW-1:0]        rd_k;

    // fetch one sample ahead so the next capture sees its data
    assign rd_k    = capture ? r_k + CW'(1) : r_k;
    assign o_raddr = rd_k[AW-1:0];
    assign fire    = o_out.valid && o_out.ready;
    assign capture = (r_state == gmn_pkg::B_LOAD) || (fire && !r_last);

    assign o_out.median_value = r_med;
    assign o_out.residual     = r_res;
    assign o_out.channel_slot = r_slot;
    assign o_out.last_result  = r_last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            gmn_pkg::B_IDLE: if (i_job_valid) n_state = gmn_pkg::B_READ;
            gmn_pkg::B_READ: n_state = gmn_pkg::B_LOAD;
            gmn_pkg::B_LOAD: n_state = gmn_pkg::B_OUT;
            gmn_pkg::B_OUT:  if (fire && r_last) n_state = gmn_pkg::B_IDLE;
            default:         n_state = gmn_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        o_out.valid = 1'b0;
        o_stat.busy = 1'b1;
        o_stat.done = 1'b0;
        case (r_state)
            gmn_pkg::B_IDLE: begin
                o_pop       = i_job_valid;
                o_stat.busy = 1'b0;
            end
            gmn_pkg::B_OUT: begin
                o_out.valid = 1'b1;
                o_stat.done = o_out.ready && r_last;
            end
            default: o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gmn_pkg::B_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_k <= '0;
            end else if (capture) begin
                r_k <= r_k + CW'(1);
            end
        end
        if (o_pop) begin
            r_n   <= i_job.count;
            r_med <= i_job.median;
        end
        // hold the result while the receiver stalls, refill on each request
        if (capture) begin
            r_res  <= {i_rdata[12], i_rdata} - {r_med[12], r_med};
            r_slot <= r_k[gmn_pkg::SLOT_W-1:0];
            r_last <= (r_k + CW'(1) == r_n);
        end
    end
endmodule
`default_nettype wire

// ----- sv/group_median_noise_removal.sv -----
// Group median noise removal.
// i_in carries one channel sample per request (sample, last_channel); the
// request with last_channel set closes the group of one time tick. Up to
// GROUP samples are kept; further ones are dropped, also the closing one.
// o_out gives one request per stored channel in load order: median_value,
// residual = sample - median, channel_slot and last_result on the final one.
// i_in is ready throughout loading. After the last sample the sorted cells
// shift to bring the middle values to the front, then the job goes through a
// two-entry queue to the output side, which pops it, steps through its read
// and load states and gives the first result from the sample memory, then
// one result per cycle while o_out is ready. i_in stalls from the last
// sample until the final result is taken.
// A stall on o_out holds the current result; nothing is lost.
// Reset (i_rst_n low, synchronous) empties the group and the queue; the
// sample memory needs no clearing.
`default_nettype none
`include "assert_macros.svh"
module group_median_noise_removal #(
    parameter int GROUP = gmn_pkg::GROUP_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gmn_in_if.sink    i_in,
    gmn_out_if.source o_out
);
    localparam int AW = (GROUP > 1) ? $clog2(GROUP) : 1;

    logic                 we;
    logic [AW-1:0]        waddr;
    gmn_pkg::t_sample     wdata;
    logic [AW-1:0]        raddr;
    gmn_pkg::t_sample     rdata;
    logic                 push;
    logic                 push_ready;
    gmn_pkg::t_job        job_in;
    gmn_pkg::t_job        job_out;
    logic                 job_valid;
    logic                 pop;
    logic [1:0]           q_level;
    gmn_pkg::t_back_stat  bstat;

    gmn_front #(.GROUP(GROUP)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_push       (push),
        .o_job        (job_in),
        .i_push_ready (push_ready),
        .i_done       (bstat.done)
    );

    gmn_ram #(.WIDTH(gmn_pkg::SAMPLE_W), .DEPTH(GROUP)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    gmn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_ready (push_ready),
        .o_valid (job_valid),
        .o_data  (job_out),
        .i_pop   (pop),
        .o_level (q_level)
    );

    gmn_back #(.GROUP(GROUP)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_out       (o_out),
        .o_stat      (bstat)
    );

    `GMN_ASSERT_NOW(a_load_idle, i_clk, i_rst_n, i_in.valid && i_in.ready, q_level == 2'd0 && !bstat.busy)
    `GMN_ASSERT_NOW(a_out_busy, i_clk, i_rst_n, o_out.valid, bstat.busy)
    `GMN_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_out.valid && o_out.ready && o_out.last_result, !o_out.valid)
endmodule
`default_nettype wire

// ----- test/group_median_noise_removal_tb.sv -----
module group_median_noise_removal_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GROUP       = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 360;

    typedef struct packed {
        gmn_pkg::t_sample           median;
        gmn_pkg::t_res              residual;
        logic [gmn_pkg::SLOT_W-1:0] slot;
        logic                       last;
    } t_residual_exp;

    typedef struct {
        int   sample;
        logic last;
        logic typed;
        int   median;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    gmn_in_if  in_if ();
    gmn_out_if out_if ();

    group_median_noise_removal #(.GROUP(GROUP)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #1 i_clk = ~i_clk;

    t_residual_exp    residual_q[$];
    gmn_pkg::t_sample group_store[GROUP];
    int               group_count = 0;
    int               mismatches = 0;
    int               cycles = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;

    initial begin
        in_if.valid = 1'b0;
        in_if.sample = '0;
        in_if.last_channel = 1'b0;
        out_if.ready = 1'b0;
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0d: %s", cycles, msg);
        mismatches++;
    endtask

    function automatic void queue_expected(input t_residual_exp e);
        residual_q.insert(residual_q.size(), e);
    endfunction

    function automatic int group_median(input int n);
        int sorted[GROUP];
        int key;
        int j;
        for (int i = 0; i < n; i++) begin
            key = group_store[i];
            j = i;
            while (j > 0 && sorted[j-1] > key) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        if (n % 2 == 1) return sorted[n/2];
        return (sorted[n/2-1] + sorted[n/2]) / 2;
    endfunction

    // update the group and queue the residuals when it closes
    function automatic void predict_residuals(input gmn_pkg::t_sample s, input logic last);
        int med;
        t_residual_exp e;
        if (group_count < GROUP) begin
            group_store[group_count] = s;
            group_count++;
        end
        if (!last || group_count == 0) return;
        med = group_median(group_count);
        for (int k = 0; k < group_count; k++) begin
            e.median   = gmn_pkg::t_sample'(med);
            e.residual = gmn_pkg::t_res'(int'(group_store[k]) - med);
            e.slot     = gmn_pkg::SLOT_W'(k);
            e.last     = (k + 1 == group_count);
            queue_expected(e);
        end
        group_count = 0;
    endfunction

    task automatic send_sample(input int s, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid        <= 1'b1;
        in_if.sample       <= gmn_pkg::t_sample'(s);
        in_if.last_channel <= last;
        do @(posedge i_clk); while (!in_if.ready);
        predict_residuals(gmn_pkg::t_sample'(s), last);
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_residual_exp e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("group_median_noise_removal verification failed");
            $finish;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (residual_q.size() == 0) begin
                report("result with nothing expected");
            end else begin
                e = residual_q.pop_front();
                if (out_if.median_value !== e.median)
                    report($sformatf("median %0d exp %0d", out_if.median_value, e.median));
                if (out_if.residual !== e.residual)
                    report($sformatf("residual %0d exp %0d", out_if.residual, e.residual));
                if (out_if.channel_slot !== e.slot)
                    report($sformatf("slot %0d exp %0d", out_if.channel_slot, e.slot));
                if (out_if.last_result !== e.last)
                    report($sformatf("last %0b exp %0b", out_if.last_result, e.last));
            end
        end
    end

    function automatic int rand_sample();
        case ($urandom_range(9))
            0: return 4095;
            1: return -4096;
            2: return int'($urandom_range(8)) - 4;
            default: return int'($urandom_range(8191)) - 4096;
        endcase
    endfunction

    t_row rows[] = '{
        '{4095, 1'b1, 1'b1, 4095},
        '{-4096, 1'b1, 1'b1, -4096},
        '{0, 1'b1, 1'b1, 0},
        '{4095, 1'b0, 1'b0, 0},
        '{-4096, 1'b1, 1'b0, 0},
        '{-4096, 1'b0, 1'b0, 0},
        '{-4096, 1'b0, 1'b0, 0},
        '{4095, 1'b1, 1'b0, 0},
        '{-3, 1'b0, 1'b0, 0},
        '{0, 1'b0, 1'b0, 0},
        '{-2, 1'b0, 1'b0, 0},
        '{5, 1'b1, 1'b0, 0},
        '{7, 1'b0, 1'b0, 0},
        '{7, 1'b0, 1'b0, 0},
        '{7, 1'b0, 1'b0, 0},
        '{-100, 1'b0, 1'b0, 0},
        '{2731, 1'b1, 1'b0, 0},
        '{-1, 1'b0, 1'b0, 0},
        '{-2, 1'b1, 1'b0, 0},
        '{1365, 1'b1, 1'b1, 1365},
        '{-2731, 1'b1, 1'b1, -2731}
    };

    initial begin
        int items;
        int size;
        t_residual_exp e;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // typed rows are single-sample groups on an empty store
        foreach (rows[r]) begin
            if (rows[r].typed) begin
                e.median   = gmn_pkg::t_sample'(rows[r].median);
                e.residual = '0;
                e.slot     = '0;
                e.last     = 1'b1;
                queue_expected(e);
                send_idle_pct = 0;
                while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
                @(negedge i_clk);
                in_if.valid        <= 1'b1;
                in_if.sample       <= gmn_pkg::t_sample'(rows[r].sample);
                in_if.last_channel <= 1'b1;
                do @(posedge i_clk); while (!in_if.ready);
            end else begin
                send_sample(rows[r].sample, rows[r].last);
            end
        end

        items = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            while (items < ITEM_TARGET * (phase + 1) / 4) begin
                case ($urandom_range(9))
                    0:       size = $urandom_range(36, 33);  // overflow drops extras
                    1, 2:    size = $urandom_range(32, 9);
                    default: size = $urandom_range(8, 1);
                endcase
                for (int i = 0; i < size; i++)
                    send_sample(rand_sample(), i == size - 1);
                items += size;
            end
        end
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        recv_stall_pct = 0;

        while (residual_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && residual_q.size() == 0) begin
            $display("group_median_noise_removal verification clean");
        end else begin
            $display("group_median_noise_removal verification failed");
        end
        $finish;
    end
endmodule
